/* hdl/ptfr_pkg.sv */
// Package: field widths, codes and shared types of the paged translation core.
package ptfr_pkg;

	// Default sizing of the block
	localparam int unsigned PAGES_DEF       = 8;
	localparam int unsigned BLOCKS_DEF      = 16;
	localparam int unsigned FRAMES_DEF      = 4;
	localparam int unsigned OFFSET_BITS_DEF = 10;

	// Fixed payload widths
	localparam int unsigned OP_W     = 1;
	localparam int unsigned PAGE_W   = 3;
	localparam int unsigned OFFSET_W = 10;
	localparam int unsigned PHYS_W   = 14;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned VPAGE_W  = 3;

	// Configuration registers
	localparam int unsigned RSV_W      = 16;
	localparam int unsigned QUOTA_W    = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUOTA    = 2'd1;

	localparam logic [QUOTA_W-1:0] QUOTA_RESET = 3'd4;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_HIT        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FAULT_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REPLACED   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NO_FRAME   = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
	} ptfr_cmd_t;

	// Configuration write toward the datapath
	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} ptfr_cfg_wr_t;

endpackage

/* hdl/ptfr_req_if.sv */
// Interface: access request channel (store flag, page, offset).
interface ptfr_req_if;
	import ptfr_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [PAGE_W-1:0]   page;
	logic [OFFSET_W-1:0] offset;

	modport source (output valid, output op, output page, output offset, input ready);
	modport sink (input valid, input op, input page, input offset, output ready);
endinterface

/* hdl/ptfr_rsp_if.sv */
// Interface: translation result channel.
interface ptfr_rsp_if;
	import ptfr_pkg::*;

	logic                valid;
	logic                ready;
	logic [PHYS_W-1:0]   phys_addr;
	logic [STATUS_W-1:0] status;
	logic [VPAGE_W-1:0]  victim_page;
	logic                victim_dirty;

	modport source (output valid, output phys_addr, output status, output victim_page,
		output victim_dirty, input ready);
	modport sink (input valid, input phys_addr, input status, input victim_page,
		input victim_dirty, output ready);
endinterface

/* hdl/ptfr_cfg_if.sv */
// Interface: configuration register write channel.
interface ptfr_cfg_if;
	import ptfr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/ptfr_ctrl.sv */
// Controller: sequences capture and execution of one access and owns result valid.
module ptfr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output ptfr_pkg::ptfr_cmd_t cmd
);
	import ptfr_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic exec;

	// Execute once the result register is free or being drained
	assign exec        = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.exec    = exec;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.capture) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (exec) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

/* hdl/ptfr_datapath.sv */
// Datapath: page table, FIFO of resident pages, block allocator and result register.
module ptfr_datapath #(
	parameter int unsigned PAGES       = ptfr_pkg::PAGES_DEF,
	parameter int unsigned BLOCKS      = ptfr_pkg::BLOCKS_DEF,
	parameter int unsigned FRAMES      = ptfr_pkg::FRAMES_DEF,
	parameter int unsigned OFFSET_BITS = ptfr_pkg::OFFSET_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ptfr_pkg::ptfr_cmd_t            cmd,
	input  ptfr_pkg::ptfr_cfg_wr_t         cfg_wr,
	input  logic [ptfr_pkg::OP_W-1:0]      in_op,
	input  logic [ptfr_pkg::PAGE_W-1:0]    in_page,
	input  logic [ptfr_pkg::OFFSET_W-1:0]  in_offset,
	output logic [ptfr_pkg::PHYS_W-1:0]    phys_addr,
	output logic [ptfr_pkg::STATUS_W-1:0]  status,
	output logic [ptfr_pkg::VPAGE_W-1:0]   victim_page,
	output logic                           victim_dirty
);
	import ptfr_pkg::*;

	// Only pages below eight can be named, so the table holds at most eight
	localparam int unsigned TBL   = (PAGES < 8) ? PAGES : 8;
	localparam int unsigned TIDX  = (TBL > 1) ? $clog2(TBL) : 1;
	localparam int unsigned BLK_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
	localparam int unsigned CNT_W = $clog2(FRAMES + 1);
	localparam int unsigned FIDX  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int unsigned QW    = (CNT_W > QUOTA_W) ? CNT_W : QUOTA_W;
	localparam int unsigned FULL_W = BLK_W + OFFSET_BITS;

	// Reduce a page number modulo the page count by repeated subtraction
	function automatic logic [PAGE_W-1:0] page_mod(input logic [PAGE_W-1:0] pg);
		logic [PAGE_W-1:0] r;
		r = pg;
		for (int k = 0; k < PAGE_W; k++) begin
			if (32'(r) >= PAGES) begin
				r = r - PAGE_W'(PAGES);
			end
		end
		return r;
	endfunction

	// Configuration registers
	logic [RSV_W-1:0]   reserved_q;
	logic [QUOTA_W-1:0] quota_q;

	// Captured access
	logic [OP_W-1:0]     op_q;
	logic [PAGE_W-1:0]   page_q;
	logic [OFFSET_W-1:0] offset_q;

	// Page table and replacement state
	logic [TBL-1:0]        resident_q;
	logic [TBL-1:0]        dirty_q;
	logic [BLK_W-1:0]      block_q [TBL];
	logic [TIDX-1:0]       fifo_q [FRAMES];
	logic [CNT_W-1:0]      count_q;
	logic [BLOCKS-1:0]     taken_q;

	// Result register
	logic [PHYS_W-1:0]   phys_q;
	logic [STATUS_W-1:0] status_q;
	logic [VPAGE_W-1:0]  vpage_q;
	logic                vdirty_q;

	// Lookup signals
	logic [TIDX-1:0]    pidx;
	logic [TIDX-1:0]    victim;
	logic               hit;
	logic [BLOCKS-1:0]  rsv_pad;
	logic               found;
	logic [BLK_W-1:0]   free_blk;
	logic [QW-1:0]      quota_eff;
	logic               grant;
	logic               replace;
	logic               no_frame;
	logic [BLK_W-1:0]   blk_sel;
	logic [FULL_W-1:0]  phys_full;
	logic [STATUS_W-1:0] status_d;

	assign pidx    = TIDX'(page_mod(page_q));
	assign victim  = fifo_q[0];
	assign hit     = resident_q[pidx];
	assign rsv_pad = BLOCKS'(reserved_q);

	// Find the lowest block that is neither taken nor reserved
	always_comb begin
		found    = 1'b0;
		free_blk = '0;
		for (int b = BLOCKS - 1; b >= 0; b--) begin
			if (!taken_q[b] && !rsv_pad[b]) begin
				found    = 1'b1;
				free_blk = BLK_W'(b);
			end
		end
	end

	// Clamp the quota to the frame count and decide the miss path
	always_comb begin
		quota_eff = (QW'(quota_q) > QW'(FRAMES)) ? QW'(FRAMES) : QW'(quota_q);
		grant     = !hit && found && (QW'(count_q) < quota_eff);
		replace   = !hit && !grant && (count_q != '0);
		no_frame  = !hit && !grant && !replace;
		if (hit) begin
			blk_sel  = block_q[pidx];
			status_d = ST_HIT;
		end else if (grant) begin
			blk_sel  = free_blk;
			status_d = ST_FAULT_FREE;
		end else if (replace) begin
			blk_sel  = block_q[victim];
			status_d = ST_REPLACED;
		end else begin
			blk_sel  = '0;
			status_d = ST_NO_FRAME;
		end
	end

	assign phys_full = {blk_sel, OFFSET_BITS'(offset_q)};

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
			quota_q    <= QUOTA_RESET;
		end else if (cfg_wr.we) begin
			if (cfg_wr.index == REG_RESERVED) begin
				reserved_q <= cfg_wr.data[RSV_W-1:0];
			end else if (cfg_wr.index == REG_QUOTA) begin
				quota_q <= cfg_wr.data[QUOTA_W-1:0];
			end
		end
	end

	// Capture the incoming transaction
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= in_op;
			page_q   <= in_page;
			offset_q <= in_offset;
		end
	end

	// Update page table, FIFO and allocator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resident_q <= '0;
			dirty_q    <= '0;
			count_q    <= '0;
			taken_q    <= '0;
			for (int i = 0; i < TBL; i++) begin
				block_q[i] <= '0;
			end
			for (int i = 0; i < FRAMES; i++) begin
				fifo_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			// A newly mapped page starts clean unless this access is a store
			if (grant) begin
				taken_q[free_blk]          <= 1'b1;
				fifo_q[FIDX'(count_q)]     <= pidx;
				count_q                    <= count_q + CNT_W'(1);
				resident_q[pidx]           <= 1'b1;
				block_q[pidx]              <= free_blk;
				dirty_q[pidx]              <= op_q[0];
			end else if (replace) begin
				for (int i = 0; i < FRAMES - 1; i++) begin
					if (CNT_W'(i + 1) < count_q) begin
						fifo_q[i] <= fifo_q[i + 1];
					end
				end
				fifo_q[FIDX'(count_q - CNT_W'(1))] <= pidx;
				resident_q[victim] <= 1'b0;
				dirty_q[victim]    <= 1'b0;
				block_q[victim]    <= '0;
				resident_q[pidx]   <= 1'b1;
				block_q[pidx]      <= block_q[victim];
				dirty_q[pidx]      <= op_q[0];
			end else if (hit && op_q[0]) begin
				// Mark a resident page dirty on a store
				dirty_q[pidx] <= 1'b1;
			end
		end
	end

	// Load the result register; a no-frame result carries a zero address
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			phys_q   <= no_frame ? '0 : PHYS_W'(phys_full);
			status_q <= status_d;
			vpage_q  <= replace ? VPAGE_W'(victim) : '0;
			vdirty_q <= replace ? dirty_q[victim] : 1'b0;
		end
	end

	assign phys_addr    = phys_q;
	assign status       = status_q;
	assign victim_page  = vpage_q;
	assign victim_dirty = vdirty_q;
endmodule

/* hdl/paged_translation_fifo_replace_core.sv */
// Top level: paged address translation with FIFO page replacement.
// Each access is captured as a request transaction and then executed, which looks up the
// page table, searches the lowest free block with a priority encoder, updates the resident
// FIFO and loads the result register; the next request is taken in the cycle after that,
// so no new access is taken before the last one has executed. A waiting result does not
// block capture of the next request; execution of that request waits until the result
// register is taken. Configuration writes are always ready and must be issued only while
// the core is idle. Reset clears the page table, FIFO and block allocator at once.
module paged_translation_fifo_replace_core #(
	parameter int unsigned PAGES       = ptfr_pkg::PAGES_DEF,
	parameter int unsigned BLOCKS      = ptfr_pkg::BLOCKS_DEF,
	parameter int unsigned FRAMES      = ptfr_pkg::FRAMES_DEF,
	parameter int unsigned OFFSET_BITS = ptfr_pkg::OFFSET_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	ptfr_req_if.sink    req,
	ptfr_rsp_if.source  rsp,
	ptfr_cfg_if.sink    cfg
);
	import ptfr_pkg::*;

	ptfr_cmd_t    cmd;
	ptfr_cfg_wr_t cfg_wr;

	// Accept configuration writes at any time
	assign cfg.ready    = 1'b1;
	assign cfg_wr.we    = cfg.valid && cfg.ready;
	assign cfg_wr.index = cfg.index;
	assign cfg_wr.data  = cfg.data;

	ptfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	ptfr_datapath #(
		.PAGES       (PAGES),
		.BLOCKS      (BLOCKS),
		.FRAMES      (FRAMES),
		.OFFSET_BITS (OFFSET_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_wr       (cfg_wr),
		.in_op        (req.op),
		.in_page      (req.page),
		.in_offset    (req.offset),
		.phys_addr    (rsp.phys_addr),
		.status       (rsp.status),
		.victim_page  (rsp.victim_page),
		.victim_dirty (rsp.victim_dirty)
	);

	// Capture and execution never overlap
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.capture && cmd.exec))
		else $error("capture and execute in the same cycle");

	// A captured request blocks the request channel in the next cycle
	a_capture_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !req.ready)
		else $error("request accepted while previous one still executing");

	// Execution always leaves a valid result
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> rsp.valid)
		else $error("executed access produced no result");

	// A no-frame result carries zero address and victim fields
	a_no_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_NO_FRAME) |->
		(rsp.phys_addr == '0 && rsp.victim_page == '0 && !rsp.victim_dirty))
		else $error("no-frame result with nonzero fields");
endmodule
